// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the vector unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clock while reset is low.
`define V3A_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every rising edge of clock, reset included.
`define V3A_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/v3a_pkg.sv -----
// ----------------------------------------------------------------------------
// v3a_pkg
// Types, opcodes, widths and helpers shared by the vector unit.
// ----------------------------------------------------------------------------
package v3a_pkg;

   localparam int unsigned FRAC_BITS_DEF = 16;
   localparam int unsigned WORD_W        = 32;
   localparam int unsigned OP_W          = 4;
   localparam int unsigned PROD_W        = 2 * WORD_W;
   localparam int unsigned WIDE_W        = PROD_W + 2;
   localparam int unsigned SQ_STEPS      = WORD_W;
   localparam int unsigned ROOT_W        = WORD_W + 1;
   localparam int unsigned QUO_W         = WORD_W + 1;

   localparam int unsigned PREP_LAT = 3;
   localparam int unsigned SQRT_LAT = SQ_STEPS + 1;
   localparam int unsigned DIV_LAT  = QUO_W + 1;
   localparam int unsigned POST_LAT = 1;
   localparam int unsigned LATENCY  = PREP_LAT + SQRT_LAT + DIV_LAT + POST_LAT;

   localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
   localparam logic [OP_W-1:0] OP_NEG   = 4'd2;
   localparam logic [OP_W-1:0] OP_SCALE = 4'd3;
   localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
   localparam logic [OP_W-1:0] OP_MAG   = 4'd5;
   localparam logic [OP_W-1:0] OP_NORM  = 4'd6;
   localparam logic [OP_W-1:0] OP_DOT   = 4'd7;
   localparam logic [OP_W-1:0] OP_CROSS = 4'd8;

   localparam logic [WORD_W-1:0] Q_MAX = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] Q_MIN = 32'h8000_0000;

   typedef logic signed [WORD_W-1:0] word_type;

   // Operands and the results that are already final when an item leaves the
   // front end; travels beside the root and divide pipes.
   typedef struct packed {
      logic [OP_W-1:0] op;
      word_type [2:0]  a;
      word_type        bx;
      word_type [2:0]  r;
      word_type        s;
      logic            sat;
   } side_type;

   typedef struct packed {
      word_type val;
      logic     sat;
   } clip_type;

   // Clips a wide signed value to the 32-bit range.
   function automatic clip_type clip_wide(input logic signed [WIDE_W-1:0] v);
      clip_type c;
      if (v[WIDE_W-1:WORD_W-1] == {(WIDE_W-WORD_W+1){v[WIDE_W-1]}}) begin
         c.val = v[WORD_W-1:0];
         c.sat = 1'b0;
      end else begin
         c.val = v[WIDE_W-1] ? Q_MIN : Q_MAX;
         c.sat = 1'b1;
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/vector3_alu_top.sv -----
// ----------------------------------------------------------------------------
// vector3_alu_top
// Three-component Q-format vector math unit, fully pipelined.
// ----------------------------------------------------------------------------
//   channel   ports                        handshake
//   request   req_opcode, req_a_*, req_b_* start high while busy low
//   response  rsp_r_*, rsp_r_scalar, flags rsp_valid for one cycle
//
// One beat enters per cycle and passes through three front-end
// stages, 32 square-root stages plus rounding, 34 divider stages
// and one output stage.
// The root and divide pipes set the depth; every opcode takes the same path.
// busy is always low; the response side cannot stall.
// Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
module vector3_alu_top #(
   parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [v3a_pkg::OP_W-1:0]        req_opcode,
   input  logic signed [v3a_pkg::WORD_W-1:0] req_a_x,
   input  logic signed [v3a_pkg::WORD_W-1:0] req_a_y,
   input  logic signed [v3a_pkg::WORD_W-1:0] req_a_z,
   input  logic signed [v3a_pkg::WORD_W-1:0] req_b_x,
   input  logic signed [v3a_pkg::WORD_W-1:0] req_b_y,
   input  logic signed [v3a_pkg::WORD_W-1:0] req_b_z,
   output logic                            rsp_valid,
   output logic signed [v3a_pkg::WORD_W-1:0] rsp_r_x,
   output logic signed [v3a_pkg::WORD_W-1:0] rsp_r_y,
   output logic signed [v3a_pkg::WORD_W-1:0] rsp_r_z,
   output logic signed [v3a_pkg::WORD_W-1:0] rsp_r_scalar,
   output logic                            rsp_saturated,
   output logic                            rsp_div_zero
);
   import v3a_pkg::*;

   word_type [2:0]    a_vec;
   word_type [2:0]    b_vec;
   logic              prep_valid;
   side_type          prep_side;
   logic [PROD_W-1:0] prep_sq;
   logic              sqrt_valid;
   side_type          sqrt_side;
   logic [ROOT_W-1:0] sqrt_root;
   logic              div_valid;
   side_type          div_side;
   logic [ROOT_W-1:0] div_root;
   logic [QUO_W-1:0]  div_quo [3];
   logic [2:0]        div_ovf;
   logic [2:0]        div_neg;
   word_type [2:0]    post_r;

   assign busy  = 1'b0;
   assign a_vec = {req_a_z, req_a_y, req_a_x};
   assign b_vec = {req_b_z, req_b_y, req_b_x};

   v3a_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_op     (req_opcode),
      .in_a      (a_vec),
      .in_b      (b_vec),
      .out_valid (prep_valid),
      .out_side  (prep_side),
      .out_sq    (prep_sq)
   );

   v3a_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_side   (prep_side),
      .in_sq     (prep_sq),
      .out_valid (sqrt_valid),
      .out_side  (sqrt_side),
      .out_root  (sqrt_root)
   );

   v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqrt_valid),
      .in_side   (sqrt_side),
      .in_root   (sqrt_root),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_root  (div_root),
      .out_quo   (div_quo),
      .out_ovf   (div_ovf),
      .out_neg   (div_neg)
   );

   v3a_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_side   (div_side),
      .in_root   (div_root),
      .in_quo    (div_quo),
      .in_ovf    (div_ovf),
      .in_neg    (div_neg),
      .out_valid (rsp_valid),
      .out_r     (post_r),
      .out_s     (rsp_r_scalar),
      .out_sat   (rsp_saturated),
      .out_dz    (rsp_div_zero)
   );

   assign rsp_r_x = post_r[0];
   assign rsp_r_y = post_r[1];
   assign rsp_r_z = post_r[2];

endmodule

// ----- hw/rtl/v3a_prep.sv -----
// ----------------------------------------------------------------------------
// v3a_prep
// Front end: products, sums, rounding and clipping for the direct operations.
// ----------------------------------------------------------------------------
module v3a_prep #(
   parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [v3a_pkg::OP_W-1:0]   in_op,
   input  v3a_pkg::word_type [2:0]    in_a,
   input  v3a_pkg::word_type [2:0]    in_b,
   output logic                       out_valid,
   output v3a_pkg::side_type          out_side,
   output logic [v3a_pkg::PROD_W-1:0] out_sq
);
   import v3a_pkg::*;

   localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) << (FRAC_BITS - 1);

   // Stage 1: six multipliers with operands chosen by opcode.
   logic signed [WORD_W-1:0] ma [6];
   logic signed [WORD_W-1:0] mb [6];
   logic signed [PROD_W-1:0] prod_in [6];

   logic                     p1_valid_ff;
   logic [OP_W-1:0]          p1_op_ff;
   word_type [2:0]           p1_a_ff;
   word_type [2:0]           p1_b_ff;
   logic signed [PROD_W-1:0] p1_prod_ff [6];

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         ma[k] = '0;
         mb[k] = '0;
      end
      case (in_op)
         OP_CROSS: begin
            ma[0] = in_a[1]; mb[0] = in_b[2];
            ma[1] = in_a[2]; mb[1] = in_b[1];
            ma[2] = in_a[2]; mb[2] = in_b[0];
            ma[3] = in_a[0]; mb[3] = in_b[2];
            ma[4] = in_a[0]; mb[4] = in_b[1];
            ma[5] = in_a[1]; mb[5] = in_b[0];
         end
         OP_DOT: begin
            for (int i = 0; i < 3; i++) begin
               ma[i] = in_a[i];
               mb[i] = in_b[i];
            end
         end
         OP_MAG, OP_NORM: begin
            for (int i = 0; i < 3; i++) begin
               ma[i] = in_a[i];
               mb[i] = in_a[i];
            end
         end
         default: begin
            for (int i = 0; i < 3; i++) begin
               ma[i] = in_a[i];
               mb[i] = in_b[0];
            end
         end
      endcase
      for (int k = 0; k < 6; k++) begin
         prod_in[k] = ma[k] * mb[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      p1_op_ff <= in_op;
      p1_a_ff  <= in_a;
      p1_b_ff  <= in_b;
      for (int k = 0; k < 6; k++) begin
         p1_prod_ff[k] <= prod_in[k];
      end
   end

   // Stage 2: exact sums and differences.
   logic signed [WORD_W:0]   lin_in [3];
   logic signed [WIDE_W-1:0] wide_in [3];
   logic [PROD_W-1:0]        sq_in;

   logic                     p2_valid_ff;
   logic [OP_W-1:0]          p2_op_ff;
   word_type [2:0]           p2_a_ff;
   word_type                 p2_bx_ff;
   logic signed [WORD_W:0]   p2_lin_ff [3];
   logic signed [WIDE_W-1:0] p2_wide_ff [3];
   logic [PROD_W-1:0]        p2_sq_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (p1_op_ff)
            OP_ADD:  lin_in[i] = (WORD_W+1)'(p1_a_ff[i]) + (WORD_W+1)'(p1_b_ff[i]);
            OP_SUB:  lin_in[i] = (WORD_W+1)'(p1_a_ff[i]) - (WORD_W+1)'(p1_b_ff[i]);
            default: lin_in[i] = -(WORD_W+1)'(p1_a_ff[i]);
         endcase
      end
      case (p1_op_ff)
         OP_CROSS: begin
            wide_in[0] = WIDE_W'(p1_prod_ff[0]) - WIDE_W'(p1_prod_ff[1]);
            wide_in[1] = WIDE_W'(p1_prod_ff[2]) - WIDE_W'(p1_prod_ff[3]);
            wide_in[2] = WIDE_W'(p1_prod_ff[4]) - WIDE_W'(p1_prod_ff[5]);
         end
         OP_DOT: begin
            wide_in[0] = WIDE_W'(p1_prod_ff[0]) + WIDE_W'(p1_prod_ff[1])
                       + WIDE_W'(p1_prod_ff[2]);
            wide_in[1] = '0;
            wide_in[2] = '0;
         end
         default: begin
            for (int i = 0; i < 3; i++) begin
               wide_in[i] = WIDE_W'(p1_prod_ff[i]);
            end
         end
      endcase
      // Squares are never negative, so the sum fits the unsigned word.
      sq_in = p1_prod_ff[0] + p1_prod_ff[1] + p1_prod_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_op_ff <= p1_op_ff;
      p2_a_ff  <= p1_a_ff;
      p2_bx_ff <= p1_b_ff[0];
      p2_sq_ff <= sq_in;
      for (int i = 0; i < 3; i++) begin
         p2_lin_ff[i]  <= lin_in[i];
         p2_wide_ff[i] <= wide_in[i];
      end
   end

   // Stage 3: round to nearest with ties away from zero, then clip.
   logic signed [WIDE_W-1:0] bias_sum [3];
   logic signed [WIDE_W-1:0] rnd [3];
   clip_type                 clip_lin [3];
   clip_type                 clip_rnd [3];
   side_type                 side_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // A negative value loses one from the bias so that a tie rounds down.
         bias_sum[i] = p2_wide_ff[i] + HALF - WIDE_W'(p2_wide_ff[i][WIDE_W-1]);
         rnd[i]      = bias_sum[i] >>> FRAC_BITS;
         clip_lin[i] = clip_wide(WIDE_W'(p2_lin_ff[i]));
         clip_rnd[i] = clip_wide(rnd[i]);
      end
      side_in.op  = p2_op_ff;
      side_in.a   = p2_a_ff;
      side_in.bx  = p2_bx_ff;
      side_in.r   = '0;
      side_in.s   = '0;
      side_in.sat = 1'b0;
      case (p2_op_ff)
         OP_ADD, OP_SUB, OP_NEG: begin
            for (int i = 0; i < 3; i++) begin
               side_in.r[i] = clip_lin[i].val;
               side_in.sat  = side_in.sat | clip_lin[i].sat;
            end
         end
         OP_SCALE, OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               side_in.r[i] = clip_rnd[i].val;
               side_in.sat  = side_in.sat | clip_rnd[i].sat;
            end
         end
         OP_DOT: begin
            side_in.s   = clip_rnd[0].val;
            side_in.sat = clip_rnd[0].sat;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_side <= side_in;
      out_sq   <= p2_sq_ff;
   end

endmodule

// ----- hw/rtl/v3a_sqrt.sv -----
// ----------------------------------------------------------------------------
// v3a_sqrt
// Pipelined square root, one result bit per stage, rounded at the end.
// ----------------------------------------------------------------------------
module v3a_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  v3a_pkg::side_type          in_side,
   input  logic [v3a_pkg::PROD_W-1:0] in_sq,
   output logic                       out_valid,
   output v3a_pkg::side_type          out_side,
   output logic [v3a_pkg::ROOT_W-1:0] out_root
);
   import v3a_pkg::*;

   logic [SQ_STEPS-1:0] valid_ff;
   side_type            side_ff [SQ_STEPS];
   logic [PROD_W-1:0]   rem_ff  [SQ_STEPS];
   logic [PROD_W-1:0]   root_ff [SQ_STEPS];
   logic [PROD_W-1:0]   rem_in  [SQ_STEPS];
   logic [PROD_W-1:0]   root_in [SQ_STEPS];

   logic [PROD_W-1:0] n_src;
   logic [PROD_W-1:0] r_src;
   logic [PROD_W-1:0] one_bit;
   logic [PROD_W-1:0] trial;

   always_comb begin
      for (int k = 0; k < SQ_STEPS; k++) begin
         if (k == 0) begin
            n_src = in_sq;
            r_src = '0;
         end else begin
            n_src = rem_ff[k-1];
            r_src = root_ff[k-1];
         end
         one_bit = PROD_W'(1) << (PROD_W - 2 - 2 * k);
         trial   = r_src + one_bit;
         if (n_src >= trial) begin
            rem_in[k]  = n_src - trial;
            root_in[k] = (r_src >> 1) + one_bit;
         end else begin
            rem_in[k]  = n_src;
            root_in[k] = r_src >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         out_valid <= 1'b0;
      end else begin
         valid_ff  <= {valid_ff[SQ_STEPS-2:0], in_valid};
         out_valid <= valid_ff[SQ_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int k = 1; k < SQ_STEPS; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      // The remainder is the input minus the floor root squared.
      out_side <= side_ff[SQ_STEPS-1];
      out_root <= ROOT_W'(root_ff[SQ_STEPS-1])
                + ROOT_W'(rem_ff[SQ_STEPS-1] > root_ff[SQ_STEPS-1]);
   end

endmodule

// ----- hw/rtl/v3a_div.sv -----
// ----------------------------------------------------------------------------
// v3a_div
// Three-lane pipelined restoring divider for divide and normalize.
// ----------------------------------------------------------------------------
module v3a_div #(
   parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  v3a_pkg::side_type          in_side,
   input  logic [v3a_pkg::ROOT_W-1:0] in_root,
   output logic                       out_valid,
   output v3a_pkg::side_type          out_side,
   output logic [v3a_pkg::ROOT_W-1:0] out_root,
   output logic [v3a_pkg::QUO_W-1:0]  out_quo [3],
   output logic [2:0]                 out_ovf,
   output logic [2:0]                 out_neg
);
   import v3a_pkg::*;

   localparam int unsigned NUM_W = WORD_W + FRAC_BITS;
   localparam int unsigned DEPTH = QUO_W + 1;

   // Entry: divisor, rounded numerators and overflow check.
   logic              bx_zero;
   logic [ROOT_W-1:0] bx_ext;
   logic [ROOT_W-1:0] bx_mag;
   logic [ROOT_W-1:0] dvs_in;
   logic              dvs_neg;
   logic [WORD_W-1:0] a_mag;
   logic [NUM_W-1:0]  ent_rem [3];
   logic [2:0]        ent_ovf;
   logic [2:0]        ent_neg;

   always_comb begin
      bx_zero = (in_side.bx == '0);
      bx_ext  = {in_side.bx[WORD_W-1], in_side.bx};
      bx_mag  = bx_ext[ROOT_W-1] ? (~bx_ext + ROOT_W'(1)) : bx_ext;
      case (in_side.op)
         OP_DIV: begin
            dvs_in  = bx_zero ? ROOT_W'(1) : bx_mag;
            dvs_neg = in_side.bx[WORD_W-1];
         end
         OP_NORM: begin
            dvs_in  = (in_root == '0) ? ROOT_W'(1) : in_root;
            dvs_neg = 1'b0;
         end
         default: begin
            dvs_in  = ROOT_W'(1);
            dvs_neg = 1'b0;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         a_mag = in_side.a[i][WORD_W-1] ? (~in_side.a[i] + WORD_W'(1)) : in_side.a[i];
         ent_rem[i] = {a_mag, {FRAC_BITS{1'b0}}} + NUM_W'(dvs_in >> 1);
         ent_ovf[i] = (ent_rem[i] >> QUO_W) >= NUM_W'(dvs_in);
         ent_neg[i] = in_side.a[i][WORD_W-1] ^ dvs_neg;
      end
   end

   logic [DEPTH-1:0]  valid_ff;
   side_type          side_ff [DEPTH];
   logic [ROOT_W-1:0] root_ff [DEPTH];
   logic [ROOT_W-1:0] dvs_ff  [DEPTH];
   logic [2:0]        ovf_ff  [DEPTH];
   logic [2:0]        neg_ff  [DEPTH];
   logic [NUM_W-1:0]  rem_ff  [DEPTH][3];
   logic [QUO_W-1:0]  quo_ff  [DEPTH][3];
   logic [NUM_W-1:0]  rem_in  [DEPTH][3];
   logic [QUO_W-1:0]  quo_in  [DEPTH][3];

   // Stage k settles quotient bit QUO_W-k.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem_in[0][i] = ent_rem[i];
         quo_in[0][i] = '0;
      end
      for (int k = 1; k < DEPTH; k++) begin
         for (int i = 0; i < 3; i++) begin
            rem_in[k][i] = rem_ff[k-1][i];
            quo_in[k][i] = quo_ff[k-1][i];
            if ((rem_ff[k-1][i] >> (QUO_W - k)) >= NUM_W'(dvs_ff[k-1])) begin
               rem_in[k][i] = rem_ff[k-1][i] - (NUM_W'(dvs_ff[k-1]) << (QUO_W - k));
               quo_in[k][i][QUO_W-k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      root_ff[0] <= in_root;
      dvs_ff[0]  <= dvs_in;
      ovf_ff[0]  <= ent_ovf;
      neg_ff[0]  <= ent_neg;
      for (int k = 1; k < DEPTH; k++) begin
         side_ff[k] <= side_ff[k-1];
         root_ff[k] <= root_ff[k-1];
         dvs_ff[k]  <= dvs_ff[k-1];
         ovf_ff[k]  <= ovf_ff[k-1];
         neg_ff[k]  <= neg_ff[k-1];
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_side  = side_ff[DEPTH-1];
   assign out_root  = root_ff[DEPTH-1];
   assign out_ovf   = ovf_ff[DEPTH-1];
   assign out_neg   = neg_ff[DEPTH-1];
   assign out_quo   = quo_ff[DEPTH-1];

endmodule

// ----- hw/rtl/v3a_post.sv -----
// ----------------------------------------------------------------------------
// v3a_post
// Back end: signs, clips and merges the divide and root results.
// ----------------------------------------------------------------------------
module v3a_post (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  v3a_pkg::side_type          in_side,
   input  logic [v3a_pkg::ROOT_W-1:0] in_root,
   input  logic [v3a_pkg::QUO_W-1:0]  in_quo [3],
   input  logic [2:0]                 in_ovf,
   input  logic [2:0]                 in_neg,
   output logic                       out_valid,
   output v3a_pkg::word_type [2:0]    out_r,
   output v3a_pkg::word_type          out_s,
   output logic                       out_sat,
   output logic                       out_dz
);
   import v3a_pkg::*;

   logic signed [QUO_W:0] signed_quo [3];
   clip_type              lane [3];
   word_type [2:0]        r_in;
   word_type              s_in;
   logic                  sat_in;
   logic                  dz_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         signed_quo[i] = in_neg[i] ? -$signed({1'b0, in_quo[i]}) : $signed({1'b0, in_quo[i]});
         if (in_ovf[i]) begin
            lane[i].val = in_neg[i] ? Q_MIN : Q_MAX;
            lane[i].sat = 1'b1;
         end else begin
            lane[i] = clip_wide(WIDE_W'(signed_quo[i]));
         end
      end
      r_in   = in_side.r;
      s_in   = in_side.s;
      sat_in = in_side.sat;
      dz_in  = 1'b0;
      case (in_side.op)
         OP_DIV: begin
            sat_in = 1'b0;
            if (in_side.bx == '0) begin
               dz_in  = 1'b1;
               sat_in = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  if (in_side.a[i] == '0) begin
                     r_in[i] = '0;
                  end else begin
                     r_in[i] = in_side.a[i][WORD_W-1] ? Q_MIN : Q_MAX;
                  end
               end
            end else begin
               for (int i = 0; i < 3; i++) begin
                  r_in[i] = lane[i].val;
                  sat_in  = sat_in | lane[i].sat;
               end
            end
         end
         OP_NORM: begin
            sat_in = 1'b0;
            if (in_root == '0) begin
               r_in = in_side.a;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  r_in[i] = lane[i].val;
                  sat_in  = sat_in | lane[i].sat;
               end
            end
         end
         OP_MAG: begin
            // The root reaches past the word when either top bit is set.
            sat_in = in_root[ROOT_W-1] | in_root[ROOT_W-2];
            s_in   = sat_in ? Q_MAX : in_root[WORD_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_r   <= r_in;
      out_s   <= s_in;
      out_sat <= sat_in;
      out_dz  <= dz_in;
   end

endmodule

// ----- hw/rtl/v3a_check.sv -----
// ----------------------------------------------------------------------------
// v3a_check
// Port-level checks for the vector unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module v3a_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic signed [v3a_pkg::WORD_W-1:0] rsp_r_x,
   input logic signed [v3a_pkg::WORD_W-1:0] rsp_r_y,
   input logic signed [v3a_pkg::WORD_W-1:0] rsp_r_z,
   input logic signed [v3a_pkg::WORD_W-1:0] rsp_r_scalar,
   input logic                            rsp_saturated,
   input logic                            rsp_div_zero
);
   import v3a_pkg::*;

   // Every accepted beat comes out after the fixed pipeline depth.
   `V3A_ASSERT(a_latency, start && !busy |-> ##LATENCY rsp_valid, "response missing")

   `V3A_ASSERT(a_dz_flags, rsp_valid && rsp_div_zero |-> rsp_saturated && rsp_r_scalar == 0, "divide by zero flags")

   // A scalar result never comes with a vector result.
   `V3A_ASSERT(a_scalar_only, rsp_valid && rsp_r_scalar != 0 |-> rsp_r_x == 0 && rsp_r_y == 0 && rsp_r_z == 0, "scalar with vector")

   `V3A_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "response after reset")

endmodule

bind vector3_alu_top v3a_check u_check (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_r_x       (rsp_r_x),
   .rsp_r_y       (rsp_r_y),
   .rsp_r_z       (rsp_r_z),
   .rsp_r_scalar  (rsp_r_scalar),
   .rsp_saturated (rsp_saturated),
   .rsp_div_zero  (rsp_div_zero)
);

// ----- sim/tb_vector3_alu_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector3_alu_top
// Drives opcode and operand beats into the vector unit, predicts each
// response in fixed point at wide width and compares every field in order.
// ----------------------------------------------------------------------------
module tb_vector3_alu_top;
   import v3a_pkg::*;

   localparam int F        = 16;
   localparam int WAIT_MAX = 2000;

   typedef struct {
      word_type x, y, z, s;
      logic     sat, dz;
   } vec_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [OP_W-1:0] req_opcode = '0;
   word_type req_a_x = '0, req_a_y = '0, req_a_z = '0;
   word_type req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic rsp_valid;
   word_type rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_scalar;
   logic rsp_saturated, rsp_div_zero;

   vec_result_type pending_results[$];
   int errors = 0;
   int beats_sent = 0;
   int responses_seen = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   vector3_alu_top #(.FRAC_BITS(F)) i_dut (
      .clock, .reset, .start, .busy, .req_opcode,
      .req_a_x, .req_a_y, .req_a_z, .req_b_x, .req_b_y, .req_b_z,
      .rsp_valid, .rsp_r_x, .rsp_r_y, .rsp_r_z, .rsp_r_scalar,
      .rsp_saturated, .rsp_div_zero
   );

   // ---------------- arithmetic helpers -------------------------------------
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam longint ONE  = 64'sd1 << F;
   localparam longint HALF = 64'sd1 << (F - 1);

   function automatic longint sat32(longint v, inout logic sat);
      if (v > QMAX) begin sat = 1'b1; return QMAX; end
      if (v < QMIN) begin sat = 1'b1; return QMIN; end
      return v;
   endfunction

   function automatic longint floor_q(longint v);
      return v >>> F;
   endfunction

   // Rounds (h * 2^F + l) / 2^F to nearest, ties away from zero.
   function automatic longint round_q(longint h, longint l);
      longint c;
      c = floor_q(l);
      h += c;
      l -= c * ONE;
      if (h >= 0) return h + ((l >= HALF) ? 1 : 0);
      return h + ((l > HALF) ? 1 : 0);
   endfunction

   function automatic longint diff_prod(longint x1, longint y1, longint x2, longint y2);
      longint p, q, hp, hq;
      p = x1 * y1;
      q = x2 * y2;
      hp = floor_q(p);
      hq = floor_q(q);
      return round_q(hp - hq, (p - hp * ONE) - (q - hq * ONE));
   endfunction

   function automatic longint div_round(longint x, longint unsigned dmag, logic dneg);
      longint unsigned num, q;
      num = longint'(x < 0 ? -x : x) << F;
      q = (num + (dmag >> 1)) / dmag;
      return ((x < 0) != dneg) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned root_round(longint unsigned s);
      longint unsigned n, res, b;
      n = s;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      if (s - res * res > res) res++;
      return res;
   endfunction

   function automatic vec_result_type vector_math(logic [OP_W-1:0] op,
                                                  word_type ax, word_type ay, word_type az,
                                                  word_type bx, word_type by, word_type bz);
      vec_result_type res;
      longint a[3], b[3], r[3], s, h, l, p, hp;
      longint unsigned sq, m;
      logic sat, dz;
      a = '{ax, ay, az};
      b = '{bx, by, bz};
      r = '{0, 0, 0};
      s = 0;
      sat = 1'b0;
      dz = 1'b0;
      case (op)
         OP_ADD: for (int i = 0; i < 3; i++) r[i] = sat32(a[i] + b[i], sat);
         OP_SUB: for (int i = 0; i < 3; i++) r[i] = sat32(a[i] - b[i], sat);
         OP_NEG: for (int i = 0; i < 3; i++) r[i] = sat32(-a[i], sat);
         OP_SCALE: for (int i = 0; i < 3; i++) begin
            p = a[i] * b[0];
            hp = floor_q(p);
            r[i] = sat32(round_q(hp, p - hp * ONE), sat);
         end
         OP_DIV: begin
            if (b[0] == 0) begin
               dz = 1'b1;
               sat = 1'b1;
               for (int i = 0; i < 3; i++)
                  r[i] = a[i] > 0 ? QMAX : (a[i] < 0 ? QMIN : 0);
            end else begin
               for (int i = 0; i < 3; i++)
                  r[i] = sat32(div_round(a[i], b[0] < 0 ? -b[0] : b[0], b[0] < 0), sat);
            end
         end
         OP_MAG, OP_NORM: begin
            sq = 0;
            for (int i = 0; i < 3; i++)
               sq += longint'(a[i] < 0 ? -a[i] : a[i]) * longint'(a[i] < 0 ? -a[i] : a[i]);
            m = root_round(sq);
            if (op == OP_MAG) begin
               if (m > QMAX) begin sat = 1'b1; s = QMAX; end
               else s = m;
            end else if (sq == 0) begin
               r = a;
            end else begin
               for (int i = 0; i < 3; i++) r[i] = sat32(div_round(a[i], m, 1'b0), sat);
            end
         end
         OP_DOT: begin
            h = 0;
            l = 0;
            for (int i = 0; i < 3; i++) begin
               p = a[i] * b[i];
               hp = floor_q(p);
               h += hp;
               l += p - hp * ONE;
            end
            s = sat32(round_q(h, l), sat);
         end
         OP_CROSS: begin
            r[0] = sat32(diff_prod(a[1], b[2], a[2], b[1]), sat);
            r[1] = sat32(diff_prod(a[2], b[0], a[0], b[2]), sat);
            r[2] = sat32(diff_prod(a[0], b[1], a[1], b[0]), sat);
         end
         default: ;
      endcase
      res.x = WORD_W'(r[0]);
      res.y = WORD_W'(r[1]);
      res.z = WORD_W'(r[2]);
      res.s = WORD_W'(s);
      res.sat = sat;
      res.dz = dz;
      return res;
   endfunction

   // ---------------- driving -------------------------------------------------
   task automatic send_beat(logic [OP_W-1:0] op, word_type ax, word_type ay, word_type az,
                            word_type bx, word_type by, word_type bz);
      req_opcode <= op;
      req_a_x <= ax; req_a_y <= ay; req_a_z <= az;
      req_b_x <= bx; req_b_y <= by; req_b_z <= bz;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(vector_math(op, ax, ay, az, bx, by, bz));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic random_gap();
      int n;
      if ($urandom_range(0, 2) != 0) return;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Mixes full-range words with small Q values and the extremes.
   function automatic word_type pick_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
         1: return 0;
         2, 3: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // ---------------- tests ---------------------------------------------------
   task automatic test_directed();
      for (int op = 0; op <= 8; op++)
         send_beat(OP_W'(op), 32'sh0001_8000, -32'sh0002_0000, 32'sh0000_4000,
                   32'sh0003_0000, 32'sh0000_8000, -32'sh0001_0000);
      send_beat(OP_ADD, Q_MAX, Q_MIN, 1, 1, -1, -1);
      send_beat(OP_SUB, Q_MIN, Q_MAX, 0, 1, -1, 0);
      send_beat(OP_NEG, Q_MIN, Q_MAX, 0, 0, 0, 0);
      send_beat(OP_SCALE, Q_MAX, Q_MIN, 32'sh0000_8000, Q_MIN, 0, 0);
      send_beat(OP_SCALE, 32'sh0000_0001, -32'sh0000_0001, 3, 32'sh0000_8000, 0, 0);
      send_beat(OP_DIV, 5, -5, 0, 0, 0, 0);
      send_beat(OP_DIV, Q_MAX, Q_MIN, 7, -1, 0, 0);
      send_beat(OP_MAG, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0);
      send_beat(OP_NORM, 0, 0, 0, 0, 0, 0);
      send_beat(OP_NORM, 1, 0, 0, 0, 0, 0);
      send_beat(OP_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      send_beat(OP_CROSS, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
      send_beat(4'd9, 1, 2, 3, 4, 5, 6);
      send_beat(4'd15, -1, -1, -1, -1, -1, -1);
      drain();
   endtask

   task automatic test_random(int count);
      logic [OP_W-1:0] op;
      for (int k = 0; k < count; k++) begin
         op = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(9, 15))
                                           : OP_W'($urandom_range(0, 8));
         // Keep a stretch without gaps in the middle of the run.
         if (k < count / 3 || k > count / 2) random_gap();
         send_beat(op, pick_word(), pick_word(), pick_word(),
                   ($urandom_range(0, 9) == 0) ? 0 : pick_word(), pick_word(), pick_word());
         if (k == count / 4) drain();
      end
   endtask

   // ---------------- checking ------------------------------------------------
   always @(posedge clock) begin
      vec_result_type e;
      if (!reset && rsp_valid) begin
         responses_seen <= responses_seen + 1;
         if (pending_results.size() == 0) begin
            $error("response beat with no pending prediction");
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_r_x !== e.x) begin
               $error("r_x expected %0d got %0d", e.x, rsp_r_x); errors++;
            end
            if (rsp_r_y !== e.y) begin
               $error("r_y expected %0d got %0d", e.y, rsp_r_y); errors++;
            end
            if (rsp_r_z !== e.z) begin
               $error("r_z expected %0d got %0d", e.z, rsp_r_z); errors++;
            end
            if (rsp_r_scalar !== e.s) begin
               $error("r_scalar expected %0d got %0d", e.s, rsp_r_scalar); errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated expected %0b got %0b", e.sat, rsp_saturated); errors++;
            end
            if (rsp_div_zero !== e.dz) begin
               $error("div_zero expected %0b got %0b", e.dz, rsp_div_zero); errors++;
            end
         end
      end
   end

   // Watchdog: counts cycles with no beat accepted on either side.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WAIT_MAX) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(650);
      drain();
      repeat (LATENCY + 10) @(negedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d predictions never answered", pending_results.size());
         errors++;
      end
      $display("Sent %0d beats across all nine operations and unused opcodes,", beats_sent);
      $display("checked %0d responses with %0d mismatches.", responses_seen, errors);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/v3a_pkg.sv
hw/rtl/v3a_prep.sv
hw/rtl/v3a_sqrt.sv
hw/rtl/v3a_div.sv
hw/rtl/v3a_post.sv
hw/rtl/vector3_alu_top.sv
hw/rtl/v3a_check.sv
sim/tb_vector3_alu_top.sv
